// ----- src/sfc_pkg.sv -----
// sfc_pkg: format codes, action codes, float constants and a float-format test for the
// storage format converter. No dependencies.
`timescale 1ns / 1ps
package sfc_pkg;

  typedef enum logic [3:0] {
    FMT_S8   = 4'd0,
    FMT_U8   = 4'd1,
    FMT_S16  = 4'd2,
    FMT_U16  = 4'd3,
    FMT_S32  = 4'd4,
    FMT_U32  = 4'd5,
    FMT_S64  = 4'd6,
    FMT_U64  = 4'd7,
    FMT_BOOL = 4'd8,
    FMT_FP16 = 4'd9,
    FMT_BF16 = 4'd10,
    FMT_FP32 = 4'd11,
    FMT_FP64 = 4'd12
  } fmt_t;

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_STORE = 1'b1;

  localparam logic [31:0] F32_INF = 32'h7F80_0000;
  localparam logic [15:0] F16_INF = 16'h7C00;

  function automatic logic fmt_is_float(logic [3:0] f);
    return (f >= FMT_FP16) && (f <= FMT_FP64);
  endfunction

endpackage

// ----- src/sfc_if.sv -----
// sfc_if: valid/ready channel interfaces for the converter.
// Depends on nothing.
`timescale 1ns / 1ps
interface sfc_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [3:0]  format;
  logic [63:0] raw_bytes;
  logic [63:0] value_bits;
  modport source (output valid, action, format, raw_bytes, value_bits, input ready);
  modport sink   (input valid, action, format, raw_bytes, value_bits, output ready);
endinterface

interface sfc_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] canonical_out;
  logic [63:0] stored_bits;
  logic        is_float;
  modport source (output valid, canonical_out, stored_bits, is_float, input ready);
  modport sink   (input valid, canonical_out, stored_bits, is_float, output ready);
endinterface

// ----- src/storage_format_converter.sv -----
// storage_format_converter: top level, three-stage conversion pipeline.
// Depends on sfc_pkg and sfc_if.
`timescale 1ns / 1ps
// Usage:
//   in_ch  (sink)  : action, format, raw_bytes, value_bits; accepted when
//                    valid && ready.
//   out_ch (source): canonical_out, stored_bits, is_float; one result item
//                    per input item, in order.
// An accepted item passes the stage 1, stage 2 and stage 3 registers before
//   out valid rises; a stall can hold it in any stage.
// Throughput: one item per cycle without stalls. Each stage holds one item
//   and a valid bit; it advances when empty or when the stage after it moves.
// Stage 1: decode fields, find msb of fp16 subnormal mantissa, split the
//   double into sign/exponent/significand and pick the fp32 rounding shift.
// Stage 2: round-to-nearest-even shift for fp32 narrowing, fp32 subnormal normalize.
// Stage 3: final packing (overflow check, fp16 / bf16 derivation, widening
//   fp32 subnormals to double) into the output register.
// Reset (synchronous, rst_n low) clears all valid bits; payload is kept.
// Stall: when out ready is low the pipe fills and in ready drops only once
//   every stage holds an item; nothing is dropped or repeated.
module storage_format_converter (
  input logic clk,
  input logic rst_n,
  sfc_in_if.sink    in_ch,
  sfc_out_if.source out_ch
);
  import sfc_pkg::*;

  logic v1_r, v2_r, v3_r;
  logic adv1, adv2, adv3;
  assign adv3 = !v3_r || out_ch.ready;
  assign adv2 = !v2_r || adv3;
  assign adv1 = !v1_r || adv2;
  assign in_ch.ready = adv1;

  // ---------------- stage 1 ----------------
  logic        act1_r;
  logic [3:0]  fmt1_r;
  logic [63:0] raw1_r;
  logic [63:0] val1_r;
  logic [31:0] f32in1_r;   // float input as fp32 (fp16 already widened)
  logic        nan1_r;     // double input NaN/inf special
  logic [52:0] sig1_r;
  logic [10:0] dexp1_r;
  logic [6:0]  sh1_r;      // rne shift, 64 = total flush

  logic [31:0] f32in_nxt;
  logic [52:0] sig_nxt;
  logic [6:0]  sh_nxt;
  logic [3:0]  p16;
  logic [9:0]  m16;
  logic [4:0]  e16;
  logic [12:0] ex32;

  always_comb begin
    m16 = in_ch.raw_bytes[9:0];
    e16 = in_ch.raw_bytes[14:10];
    p16 = 4'd0;
    for (int i = 0; i < 10; i++) if (m16[i]) p16 = 4'(i);
    f32in_nxt = in_ch.raw_bytes[31:0];
    case (in_ch.format)
      FMT_FP16: begin
        if (e16 == 5'd0) begin
          if (m16 == 10'd0) f32in_nxt = {in_ch.raw_bytes[15], 31'd0};
          else f32in_nxt = {in_ch.raw_bytes[15], 8'(p16 + 8'd103),
                            23'((33'(m16) << (5'd23 - 5'(p16))))};
        end else if (e16 == 5'h1F)
          f32in_nxt = {in_ch.raw_bytes[15], 8'hFF, m16, 13'd0};
        else
          f32in_nxt = {in_ch.raw_bytes[15], 8'(e16) + 8'd112, m16, 13'd0};
      end
      FMT_BF16: f32in_nxt = {in_ch.raw_bytes[15:0], 16'd0};
      default: ;
    endcase
    // double -> fp32 preparation
    if (in_ch.value_bits[62:52] == 11'd0) begin
      sig_nxt = {1'b0, in_ch.value_bits[51:0]};
      ex32 = 13'sd1 - 13'sd896;
    end else begin
      sig_nxt = {1'b1, in_ch.value_bits[51:0]};
      ex32 = 13'(in_ch.value_bits[62:52]) - 13'd896;
    end
    if (!ex32[12] && ex32 != 13'd0) sh_nxt = 7'd29;
    else if ((13'd30 - ex32) >= 13'd64) sh_nxt = 7'd64;
    else sh_nxt = 7'(13'd30 - ex32);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (adv1) v1_r <= in_ch.valid;
    if (adv1) begin
      act1_r   <= in_ch.action;
      fmt1_r   <= in_ch.format;
      raw1_r   <= in_ch.raw_bytes;
      val1_r   <= in_ch.value_bits;
      f32in1_r <= f32in_nxt;
      nan1_r   <= in_ch.value_bits[62:52] == 11'h7FF;
      sig1_r   <= sig_nxt;
      dexp1_r  <= in_ch.value_bits[62:52];
      sh1_r    <= sh_nxt;
    end
  end

  // ---------------- stage 2 ----------------
  logic        act2_r, nan2_r;
  logic [3:0]  fmt2_r;
  logic [63:0] raw2_r, val2_r;
  logic [31:0] f32in2_r;
  logic [10:0] dexp2_r;
  logic [53:0] q2_r;       // rounded significand
  logic [7:0]  sp2_r;      // fp32 subnormal widen: exponent field
  logic [22:0] sm2_r;      // fp32 subnormal widen: mantissa

  logic [53:0] q_nxt;
  logic [63:0] rem, half, mask;
  logic [4:0]  p32;
  logic [22:0] m32;

  always_comb begin
    if (sh1_r >= 7'd64) begin
      q_nxt = 54'd0;
      rem = 64'd0; half = 64'd0; mask = 64'd0;
    end else begin
      mask = (64'd1 << sh1_r[5:0]) - 64'd1;
      half = 64'd1 << (sh1_r[5:0] - 6'd1);
      q_nxt = 54'(sig1_r >> sh1_r[5:0]);
      rem = 64'(sig1_r) & mask;
      if (rem > half || (rem == half && q_nxt[0])) q_nxt = q_nxt + 54'd1;
    end
    m32 = f32in1_r[22:0];
    p32 = 5'd0;
    for (int i = 0; i < 23; i++) if (m32[i]) p32 = 5'(i);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (adv2) v2_r <= v1_r;
    if (adv2) begin
      act2_r   <= act1_r;
      nan2_r   <= nan1_r;
      fmt2_r   <= fmt1_r;
      raw2_r   <= raw1_r;
      val2_r   <= val1_r;
      f32in2_r <= f32in1_r;
      dexp2_r  <= dexp1_r;
      q2_r     <= q_nxt;
      sp2_r    <= 8'(p32);
      sm2_r    <= 23'((46'(m32) << (6'd23 - 6'(p32))));
    end
  end

  // ---------------- stage 3 ----------------
  logic [63:0] canon_nxt, stored_nxt, f64w;
  logic [31:0] f32o;
  logic [33:0] r32;
  logic [8:0]  e16x;
  logic [7:0]  fe;

  always_comb begin
    r32 = 34'd0;
    // widen fp32 -> double
    fe = f32in2_r[30:23];
    if (fe == 8'hFF) begin
      if (f32in2_r[22:0] == 23'd0) f64w = {f32in2_r[31], 63'h7FF0_0000_0000_0000};
      // NaN: quiet bit forced, payload kept
      else f64w = {f32in2_r[31], 11'h7FF, 1'b1, f32in2_r[21:0], 29'd0};
    end else if (fe == 8'd0) begin
      if (f32in2_r[22:0] == 23'd0) f64w = {f32in2_r[31], 63'd0};
      else f64w = {f32in2_r[31], 11'(sp2_r) + 11'd874, sm2_r, 29'd0};
    end else
      f64w = {f32in2_r[31], 11'(fe) + 11'd896, f32in2_r[22:0], 29'd0};
    // narrow double -> fp32
    if (nan2_r) begin
      if (val2_r[51:0] == 52'd0) f32o = {val2_r[63], F32_INF[30:0]};
      else f32o = {val2_r[63], 31'h7FC0_0000 | 31'(val2_r[51:29])};
    end else if (dexp2_r == 11'd0 && val2_r[51:0] == 52'd0)
      f32o = {val2_r[63], 31'd0};
    else if (dexp2_r > 11'd896) begin
      r32 = (34'(dexp2_r - 11'd897) << 23) + 34'(q2_r);
      if (r32 >= 34'(F32_INF)) f32o = {val2_r[63], F32_INF[30:0]};
      else f32o = {val2_r[63], r32[30:0]};
    end else
      f32o = {val2_r[63], q2_r[30:0]};
    e16x = 9'(f32o[30:23]) - 9'd112;

    canon_nxt = 64'd0;
    stored_nxt = 64'd0;
    if (act2_r == ACT_LOAD) begin
      case (fmt2_r)
        FMT_S8:   canon_nxt = 64'(signed'(raw2_r[7:0]));
        FMT_U8:   canon_nxt = {56'd0, raw2_r[7:0]};
        FMT_S16:  canon_nxt = 64'(signed'(raw2_r[15:0]));
        FMT_U16:  canon_nxt = {48'd0, raw2_r[15:0]};
        FMT_S32:  canon_nxt = 64'(signed'(raw2_r[31:0]));
        FMT_U32:  canon_nxt = {32'd0, raw2_r[31:0]};
        FMT_S64, FMT_U64, FMT_FP64: canon_nxt = raw2_r;
        FMT_BOOL: canon_nxt = {63'd0, raw2_r[7:0] != 8'd0};
        FMT_FP16, FMT_BF16, FMT_FP32: canon_nxt = f64w;
        default:  canon_nxt = 64'd0;
      endcase
    end else begin
      case (fmt2_r)
        FMT_S8, FMT_U8:   stored_nxt = {56'd0, val2_r[7:0]};
        FMT_S16, FMT_U16: stored_nxt = {48'd0, val2_r[15:0]};
        FMT_S32, FMT_U32: stored_nxt = {32'd0, val2_r[31:0]};
        FMT_S64, FMT_U64, FMT_FP64: stored_nxt = val2_r;
        FMT_BOOL: stored_nxt = {63'd0, val2_r != 64'd0};
        FMT_FP16: begin
          // biased exponent <= 0 underflows, >= 31 saturates to infinity
          if (f32o[30:23] <= 8'd112) stored_nxt = {48'd0, f32o[31], 15'd0};
          else if (e16x >= 9'd31) stored_nxt = {48'd0, f32o[31], F16_INF[14:0]};
          else stored_nxt = {48'd0, f32o[31], e16x[4:0], f32o[22:13]};
        end
        FMT_BF16: stored_nxt = {48'd0, f32o[31:16]};
        FMT_FP32: stored_nxt = {32'd0, f32o};
        default:  stored_nxt = 64'd0;
      endcase
    end
  end

  logic [63:0] canon3_r, stored3_r;
  logic        flt3_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else if (adv3) v3_r <= v2_r;
    if (adv3) begin
      canon3_r  <= canon_nxt;
      stored3_r <= stored_nxt;
      flt3_r    <= fmt_is_float(fmt2_r);
    end
  end

  assign out_ch.valid         = v3_r;
  assign out_ch.canonical_out = canon3_r;
  assign out_ch.stored_bits   = stored3_r;
  assign out_ch.is_float      = flt3_r;
endmodule

// ----- src/sfc_checker.sv -----
// sfc_checker: port-level assertions for storage_format_converter.
// Depends on sfc_pkg; bound to the top level.
`timescale 1ns / 1ps
module sfc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] out_canonical_out,
  input logic [63:0] out_stored_bits
);
  import sfc_pkg::*;

  // stalled output holds its stored bits
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_stored_bits))
    else $error("output changed under stall");

  // input is ready whenever the output side is draining
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input ready dropped while output drains");

  // a load result never carries store bits and vice versa
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_canonical_out == 64'd0) || (out_stored_bits == 64'd0))
    else $error("both result words nonzero");

  // an item taken while out ready is high reaches the output unless stalled
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && out_ready |=> ##2 (out_valid || !$past(out_ready, 1)
      || !$past(out_ready, 2)))
    else $error("result missing after three cycles");
endmodule

bind storage_format_converter sfc_checker u_sfc_checker (
  .clk(clk),
  .rst_n(rst_n),
  .in_valid(in_ch.valid),
  .in_ready(in_ch.ready),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .out_canonical_out(out_ch.canonical_out),
  .out_stored_bits(out_ch.stored_bits)
);
